/* src/dt_pkg.sv */
// Shared constants and types of the Delaunay triangulation block.
package dt_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int COORD_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int VW          = 5;
  localparam int STORE_DEPTH = MAX_POINTS + 3;
  localparam int LIST_DEPTH  = 72;
  localparam int MAX_RESULTS = 64;

  localparam int IW  = $clog2(STORE_DEPTH);     // point index
  localparam int NW  = $clog2(MAX_POINTS + 1);  // point count
  localparam int LW  = $clog2(LIST_DEPTH + 1);  // list count
  localparam int LA  = $clog2(LIST_DEPTH);      // list address
  localparam int KW  = $clog2(MAX_RESULTS + 1); // result count
  localparam int PW  = COORD_BITS + 8;          // stored coordinate
  localparam int DW  = PW + 1;                  // coordinate difference
  localparam int PRW = 2 * DW;                  // small product
  localparam int XW  = PRW + 1;                 // sum of two products
  localparam int AW  = 2 * XW + 2;              // determinant accumulator

  typedef struct packed {
    logic                 start;
    logic                 clear;
    logic signed [XW-1:0] mcand;
    logic [XW-2:0]        mplier;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic neg;
    logic zero;
  } mac_stat_t;

endpackage

/* src/dt_if.sv */
// Handshake interfaces for the point input and triangle output channels.
interface dt_point_if import dt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] point_x;
  logic [FIELD_W-1:0] point_y;
  logic               last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface dt_tri_if import dt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [VW-1:0] vertex_a;
  logic [VW-1:0] vertex_b;
  logic [VW-1:0] vertex_c;
  logic          has_triangle;
  logic          overflow;
  logic          last_triangle;

  modport source (output valid, vertex_a, vertex_b, vertex_c, has_triangle, overflow,
                  last_triangle, input ready);
  modport sink   (input valid, vertex_a, vertex_b, vertex_c, has_triangle, overflow,
                  last_triangle, output ready);
endinterface

/* src/dt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module dt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dt_mac.sv */
// Bit-serial signed multiply-accumulate for the wide incircle determinant.
module dt_mac import dt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mac_cmd_t  cmd,
  output mac_stat_t stat
);

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] mcand;
  logic [XW-2:0]        mpl;
  logic                 busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      mcand <= AW'(cmd.mcand);
      mpl   <= cmd.mplier;
      busy  <= (cmd.mplier != '0);
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mpl[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      mpl   <= mpl >> 1;
      // stop once no set multiplier bits remain
      busy  <= (mpl[XW-2:1] != '0);
    end
  end

  assign stat.busy = busy;
  assign stat.neg  = acc[AW-1];
  assign stat.zero = (acc == '0);

endmodule

/* src/delaunay_triangulation.sv */
// Top level: Bowyer-Watson Delaunay triangulation of up to MAX_POINTS points.
//
// Points are taken one word per cycle while the block is idle; the word with
// last_point set starts a run. The run inserts the points in input order into
// a super-triangle and then streams out every surviving triangle that uses no
// super-triangle vertex, one word each, the final word flagged. All state
// lives in four registered-read RAMs (points, triangles, bad list, cavity
// edges). Per inserted point the incircle scan visits each of the T live
// triangles: RAM reads, the shared 25x25 multiplier and three bit-serial
// accumulator passes, which set the run time. Cavity edge bookkeeping adds a
// linear edge search per bad triangle edge. Fewer than three points yields
// one empty word. Points beyond MAX_POINTS are dropped and flag overflow.
module delaunay_triangulation import dt_pkg::*; (
  input logic       clk,
  input logic       rst,
  dt_point_if.sink  points,
  dt_tri_if.source  triangles
);

  // sequencer states
  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_SUP0  = 6'd1;
  localparam logic [5:0] S_SUP1  = 6'd2;
  localparam logic [5:0] S_SUP2  = 6'd3;
  localparam logic [5:0] S_INS   = 6'd4;
  localparam logic [5:0] S_INSW  = 6'd5;
  localparam logic [5:0] S_SCT   = 6'd6;
  localparam logic [5:0] S_SCTW  = 6'd7;
  localparam logic [5:0] S_SCA   = 6'd8;
  localparam logic [5:0] S_SCB   = 6'd9;
  localparam logic [5:0] S_SCC   = 6'd10;
  localparam logic [5:0] S_MULS  = 6'd11;
  localparam logic [5:0] S_MAC   = 6'd12;
  localparam logic [5:0] S_MACW  = 6'd13;
  localparam logic [5:0] S_SCDEC = 6'd14;
  localparam logic [5:0] S_EDB   = 6'd15;
  localparam logic [5:0] S_EDBW  = 6'd16;
  localparam logic [5:0] S_EDTW  = 6'd17;
  localparam logic [5:0] S_EDE   = 6'd18;
  localparam logic [5:0] S_EDS   = 6'd19;
  localparam logic [5:0] S_EDSW  = 6'd20;
  localparam logic [5:0] S_MV    = 6'd21;
  localparam logic [5:0] S_MVW   = 6'd22;
  localparam logic [5:0] S_EDNX  = 6'd23;
  localparam logic [5:0] S_RMB   = 6'd24;
  localparam logic [5:0] S_RMBW  = 6'd25;
  localparam logic [5:0] S_RMTW  = 6'd26;
  localparam logic [5:0] S_APE   = 6'd27;
  localparam logic [5:0] S_APEW  = 6'd28;
  localparam logic [5:0] S_APA   = 6'd29;
  localparam logic [5:0] S_APB   = 6'd30;
  localparam logic [5:0] S_APDEC = 6'd31;
  localparam logic [5:0] S_OTT   = 6'd32;
  localparam logic [5:0] S_OTTW  = 6'd33;
  localparam logic [5:0] S_OTCHK = 6'd34;
  localparam logic [5:0] S_OTEND = 6'd35;

  // multiplier step schedule: squares, then the three 2x2 cross terms
  localparam logic [3:0] MUL_FIRST = 4'd0;
  localparam logic [3:0] MUL_CROSS = 4'd10;
  localparam logic [3:0] MUL_LAST  = 4'd12;

  localparam logic [1:0] PH_X1 = 2'd0;
  localparam logic [1:0] PH_X2 = 2'd1;
  localparam logic [1:0] PH_X3 = 2'd2;

  logic [5:0] state;

  // input side
  logic [NW-1:0]                point_count;
  logic signed [COORD_BITS-1:0] bb_minx, bb_maxx, bb_miny, bb_maxy;
  logic                         overflow_seen;

  // insertion control
  logic [NW-1:0] i;
  logic [LW-1:0] tc, bc, ec, j, k, m;
  logic [LA-1:0] ridx;
  logic [1:0]    eidx;
  logic [IW-1:0] tv0, tv1, tv2, ea, eb;

  // geometry
  logic signed [PW-1:0]  px, py;
  logic signed [DW-1:0]  ax, ay, bx, by, cx, cy;
  logic signed [PRW-1:0] prod;
  logic signed [XW-1:0]  sa, sb, sc, x1, x2, x3;
  logic [3:0]            mcnt;
  logic                  mfirst, mret;
  logic [1:0]            mph;

  // output collection
  logic [KW-1:0] kept;
  logic          pend;
  logic [IW-1:0] pa, pb, pc;
  logic          ovalid;
  logic [VW-1:0] o_a, o_b, o_c;
  logic          o_has, o_ovf, o_last;

  // RAM ports
  logic                pt_we;
  logic [IW-1:0]       pt_waddr, pt_raddr;
  logic [2*PW-1:0]     pt_wdata, pt_rdata;
  logic                tr_we;
  logic [LA-1:0]       tr_waddr, tr_raddr;
  logic [3*IW-1:0]     tr_wdata, tr_rdata;
  logic                bd_we;
  logic [LA-1:0]       bd_waddr, bd_raddr;
  logic [LA-1:0]       bd_wdata, bd_rdata;
  logic                ed_we;
  logic [LA-1:0]       ed_waddr, ed_raddr;
  logic [2*IW-1:0]     ed_wdata, ed_rdata;

  mac_cmd_t  mac_cmd;
  mac_stat_t mac_stat;

  dt_ram #(.WIDTH(2*PW), .DEPTH(STORE_DEPTH)) u_pts (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );
  dt_ram #(.WIDTH(3*IW), .DEPTH(LIST_DEPTH)) u_tris (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );
  dt_ram #(.WIDTH(LA), .DEPTH(LIST_DEPTH)) u_bad (
    .clk(clk), .we(bd_we), .waddr(bd_waddr), .wdata(bd_wdata),
    .raddr(bd_raddr), .rdata(bd_rdata)
  );
  dt_ram #(.WIDTH(2*IW), .DEPTH(LIST_DEPTH)) u_edges (
    .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
    .raddr(ed_raddr), .rdata(ed_rdata)
  );

  dt_mac u_mac (.clk(clk), .rst(rst), .cmd(mac_cmd), .stat(mac_stat));

  // handshake
  logic in_acc, ofree;
  assign points.ready = (state == S_IDLE);
  assign in_acc = points.valid && points.ready;
  assign ofree  = !ovalid || triangles.ready;

  assign triangles.valid         = ovalid;
  assign triangles.vertex_a      = o_a;
  assign triangles.vertex_b      = o_b;
  assign triangles.vertex_c      = o_c;
  assign triangles.has_triangle  = o_has;
  assign triangles.overflow      = o_ovf;
  assign triangles.last_triangle = o_last;

  // incoming point, low COORD_BITS sign-extended, and its doubled form
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic signed [PW-1:0]         in_x2, in_y2;
  assign in_x  = points.point_x[COORD_BITS-1:0];
  assign in_y  = points.point_y[COORD_BITS-1:0];
  assign in_x2 = PW'(in_x) <<< 1;
  assign in_y2 = PW'(in_y) <<< 1;

  // super-triangle in half units: centre is min+max, extent is 2*max(dx,dy)
  logic signed [PW-1:0] sup_cx, sup_cy, sup_dx, sup_dy, sup_d, sup_d20;
  assign sup_cx  = PW'(bb_minx) + PW'(bb_maxx);
  assign sup_cy  = PW'(bb_miny) + PW'(bb_maxy);
  assign sup_dx  = PW'(bb_maxx) - PW'(bb_minx);
  assign sup_dy  = PW'(bb_maxy) - PW'(bb_miny);
  assign sup_d   = ((sup_dx > sup_dy) ? sup_dx : sup_dy) <<< 1;
  assign sup_d20 = (sup_d <<< 4) + (sup_d <<< 2);

  logic [IW-1:0] n_idx;
  assign n_idx = IW'(point_count);

  // point read data relative to the point being inserted
  logic signed [PW-1:0] rd_x, rd_y;
  logic signed [DW-1:0] rel_x, rel_y;
  assign rd_x  = pt_rdata[2*PW-1:PW];
  assign rd_y  = pt_rdata[PW-1:0];
  assign rel_x = DW'(rd_x) - DW'(px);
  assign rel_y = DW'(rd_y) - DW'(py);

  // shared small multiplier
  logic signed [DW-1:0]  mop1, mop2;
  logic signed [PRW-1:0] mul_w;
  logic signed [XW-1:0]  prod_x;
  logic [3:0]            cidx;
  always_comb begin
    case (mcnt)
      4'd0:    begin mop1 = ax; mop2 = ax; end
      4'd1:    begin mop1 = ay; mop2 = ay; end
      4'd2:    begin mop1 = bx; mop2 = bx; end
      4'd3:    begin mop1 = by; mop2 = by; end
      4'd4:    begin mop1 = cx; mop2 = cx; end
      4'd5:    begin mop1 = cy; mop2 = cy; end
      4'd6:    begin mop1 = bx; mop2 = cy; end
      4'd7:    begin mop1 = by; mop2 = cx; end
      4'd8:    begin mop1 = ax; mop2 = cy; end
      4'd9:    begin mop1 = ay; mop2 = cx; end
      4'd10:   begin mop1 = ax; mop2 = by; end
      4'd11:   begin mop1 = ay; mop2 = bx; end
      default: begin mop1 = '0; mop2 = '0; end
    endcase
  end
  assign mul_w  = mop1 * mop2;
  assign prod_x = XW'(prod);
  assign cidx   = mcnt - 4'd1;

  // orientation of (a,b,c) equals X1 - X2 + X3 of the p-relative vectors
  logic signed [XW+1:0] orient;
  logic                 in_circ;
  assign orient  = (XW+2)'(x1) - (XW+2)'(x2) + (XW+2)'(x3);
  assign in_circ = (orient > 0) ? (!mac_stat.neg && !mac_stat.zero) : mac_stat.neg;

  // edge-list shift bound
  logic [LW:0] m_plus;
  assign m_plus = {1'b0, m} + 1'b1;

  logic [LW-1:0] jm1, tcm1;
  assign jm1  = j - 1'b1;
  assign tcm1 = tc - 1'b1;

  logic qual;
  assign qual = (tv0 < n_idx) && (tv1 < n_idx) && (tv2 < n_idx);

  // output register loads a new word this cycle
  logic out_load;
  assign out_load = ((state == S_OTCHK) && qual && pend && ofree) ||
                    ((state == S_OTEND) && ofree);

  // accumulator commands
  always_comb begin
    mac_cmd.start  = (state == S_MAC);
    mac_cmd.clear  = (mph == PH_X1);
    case (mph)
      PH_X1:   begin mac_cmd.mcand = x1;  mac_cmd.mplier = sa[XW-2:0]; end
      PH_X2:   begin mac_cmd.mcand = -x2; mac_cmd.mplier = sb[XW-2:0]; end
      default: begin mac_cmd.mcand = x3;  mac_cmd.mplier = sc[XW-2:0]; end
    endcase
  end

  // RAM address and write control
  always_comb begin
    pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0; pt_raddr = '0;
    tr_we = 1'b0; tr_waddr = '0; tr_wdata = '0; tr_raddr = '0;
    bd_we = 1'b0; bd_waddr = '0; bd_wdata = '0; bd_raddr = '0;
    ed_we = 1'b0; ed_waddr = '0; ed_wdata = '0; ed_raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_acc && (point_count < NW'(MAX_POINTS))) begin
          pt_we    = 1'b1;
          pt_waddr = n_idx;
          pt_wdata = {in_x2, in_y2};
        end
      end
      S_SUP0: begin
        pt_we    = (point_count >= NW'(3));
        pt_waddr = n_idx;
        pt_wdata = {sup_cx - sup_d20, sup_cy - sup_d};
      end
      S_SUP1: begin
        pt_we    = 1'b1;
        pt_waddr = n_idx + 1'b1;
        pt_wdata = {sup_cx, sup_cy + sup_d20};
        tr_we    = 1'b1;
        tr_waddr = '0;
        tr_wdata = {n_idx, n_idx + IW'(1), n_idx + IW'(2)};
      end
      S_SUP2: begin
        pt_we    = 1'b1;
        pt_waddr = n_idx + IW'(2);
        pt_wdata = {sup_cx + sup_d20, sup_cy - sup_d};
      end
      S_INS:   pt_raddr = IW'(i);
      S_SCT:   tr_raddr = j[LA-1:0];
      S_SCTW:  pt_raddr = tr_rdata[3*IW-1:2*IW];
      S_SCA:   pt_raddr = tv1;
      S_SCB:   pt_raddr = tv2;
      S_SCDEC: begin
        bd_we    = in_circ && (bc < LW'(LIST_DEPTH));
        bd_waddr = bc[LA-1:0];
        bd_wdata = j[LA-1:0];
      end
      S_EDB:   bd_raddr = j[LA-1:0];
      S_EDBW:  tr_raddr = bd_rdata;
      S_EDS: begin
        if (k != ec) begin
          ed_raddr = k[LA-1:0];
        end else begin
          ed_we    = (ec < LW'(LIST_DEPTH));
          ed_waddr = ec[LA-1:0];
          ed_wdata = {ea, eb};
        end
      end
      S_MV:    ed_raddr = m_plus[LA-1:0];
      S_MVW: begin
        ed_we    = 1'b1;
        ed_waddr = m[LA-1:0];
        ed_wdata = ed_rdata;
      end
      S_RMB:   bd_raddr = jm1[LA-1:0];
      S_RMBW:  tr_raddr = tcm1[LA-1:0];
      S_RMTW: begin
        tr_we    = 1'b1;
        tr_waddr = ridx;
        tr_wdata = tr_rdata;
      end
      S_APE:   ed_raddr = j[LA-1:0];
      S_APEW:  pt_raddr = ed_rdata[2*IW-1:IW];
      S_APA:   pt_raddr = eb;
      S_APDEC: begin
        tr_we    = (tc < LW'(LIST_DEPTH));
        tr_waddr = tc[LA-1:0];
        // not counter-clockwise, collinear included: swap first two
        tr_wdata = (x3 > 0) ? {ea, eb, IW'(i)} : {eb, ea, IW'(i)};
      end
      S_OTT:   tr_raddr = j[LA-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= '0;
      bb_minx       <= '0;
      bb_maxx       <= '0;
      bb_miny       <= '0;
      bb_maxy       <= '0;
      overflow_seen <= 1'b0;
      ovalid        <= 1'b0;
      pend          <= 1'b0;
      tc            <= '0;
    end else begin
      if (ovalid && triangles.ready && !out_load) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (point_count < NW'(MAX_POINTS)) begin
              if (point_count == '0) begin
                bb_minx <= in_x; bb_maxx <= in_x;
                bb_miny <= in_y; bb_maxy <= in_y;
              end else begin
                if (in_x < bb_minx) bb_minx <= in_x;
                if (in_x > bb_maxx) bb_maxx <= in_x;
                if (in_y < bb_miny) bb_miny <= in_y;
                if (in_y > bb_maxy) bb_maxy <= in_y;
              end
              point_count <= point_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (points.last_point) begin
              state <= S_SUP0;
            end
          end
        end
        S_SUP0: begin
          kept <= '0;
          pend <= 1'b0;
          j    <= '0;
          state <= (point_count < NW'(3)) ? S_OTEND : S_SUP1;
        end
        S_SUP1: begin
          tc    <= LW'(1);
          state <= S_SUP2;
        end
        S_SUP2: begin
          i     <= '0;
          state <= S_INS;
        end
        S_INS: state <= S_INSW;
        S_INSW: begin
          px    <= rd_x;
          py    <= rd_y;
          bc    <= '0;
          j     <= '0;
          state <= S_SCT;
        end

        // incircle scan over the live triangles
        S_SCT: begin
          if (j == tc) begin
            ec    <= '0;
            j     <= '0;
            state <= S_EDB;
          end else begin
            state <= S_SCTW;
          end
        end
        S_SCTW: begin
          tv0   <= tr_rdata[3*IW-1:2*IW];
          tv1   <= tr_rdata[2*IW-1:IW];
          tv2   <= tr_rdata[IW-1:0];
          state <= S_SCA;
        end
        S_SCA: begin
          ax <= rel_x; ay <= rel_y;
          state <= S_SCB;
        end
        S_SCB: begin
          bx <= rel_x; by <= rel_y;
          state <= S_SCC;
        end
        S_SCC: begin
          cx <= rel_x; cy <= rel_y;
          mcnt   <= MUL_FIRST;
          mfirst <= 1'b1;
          mret   <= 1'b0;
          state  <= S_MULS;
        end
        S_MULS: begin
          if (mcnt != MUL_LAST) begin
            prod <= mul_w;
          end
          mfirst <= 1'b0;
          if (!mfirst) begin
            case (cidx)
              4'd0:    sa <= prod_x;
              4'd1:    sa <= sa + prod_x;
              4'd2:    sb <= prod_x;
              4'd3:    sb <= sb + prod_x;
              4'd4:    sc <= prod_x;
              4'd5:    sc <= sc + prod_x;
              4'd6:    x1 <= prod_x;
              4'd7:    x1 <= x1 - prod_x;
              4'd8:    x2 <= prod_x;
              4'd9:    x2 <= x2 - prod_x;
              4'd10:   x3 <= prod_x;
              4'd11:   x3 <= x3 - prod_x;
              default: ;
            endcase
          end
          if (mcnt == MUL_LAST) begin
            mph   <= PH_X1;
            state <= mret ? S_APDEC : S_MAC;
          end else begin
            mcnt <= mcnt + 4'd1;
          end
        end
        S_MAC: state <= S_MACW;
        S_MACW: begin
          if (!mac_stat.busy) begin
            if (mph == PH_X3) begin
              state <= S_SCDEC;
            end else begin
              mph   <= mph + 2'd1;
              state <= S_MAC;
            end
          end
        end
        S_SCDEC: begin
          if (in_circ && (bc < LW'(LIST_DEPTH))) begin
            bc <= bc + 1'b1;
          end
          j     <= j + 1'b1;
          state <= S_SCT;
        end

        // cavity boundary: shared edges cancel
        S_EDB: begin
          if (j == bc) begin
            j     <= bc;
            state <= S_RMB;
          end else begin
            state <= S_EDBW;
          end
        end
        S_EDBW: state <= S_EDTW;
        S_EDTW: begin
          tv0   <= tr_rdata[3*IW-1:2*IW];
          tv1   <= tr_rdata[2*IW-1:IW];
          tv2   <= tr_rdata[IW-1:0];
          eidx  <= 2'd0;
          state <= S_EDE;
        end
        S_EDE: begin
          case (eidx)
            2'd0:    begin ea <= tv0; eb <= tv1; end
            2'd1:    begin ea <= tv1; eb <= tv2; end
            default: begin ea <= tv2; eb <= tv0; end
          endcase
          k     <= '0;
          state <= S_EDS;
        end
        S_EDS: begin
          if (k == ec) begin
            if (ec < LW'(LIST_DEPTH)) begin
              ec <= ec + 1'b1;
            end
            state <= S_EDNX;
          end else begin
            state <= S_EDSW;
          end
        end
        S_EDSW: begin
          if (ed_rdata == {eb, ea}) begin
            m     <= k;
            state <= S_MV;
          end else begin
            k     <= k + 1'b1;
            state <= S_EDS;
          end
        end
        S_MV: begin
          if (m_plus >= {1'b0, ec}) begin
            ec    <= ec - 1'b1;
            state <= S_EDNX;
          end else begin
            state <= S_MVW;
          end
        end
        S_MVW: begin
          m     <= m + 1'b1;
          state <= S_MV;
        end
        S_EDNX: begin
          if (eidx == 2'd2) begin
            j     <= j + 1'b1;
            state <= S_EDB;
          end else begin
            eidx  <= eidx + 2'd1;
            state <= S_EDE;
          end
        end

        // swap-remove bad triangles, highest index first
        S_RMB: begin
          if (j == '0) begin
            state <= S_APE;
          end else begin
            state <= S_RMBW;
          end
        end
        S_RMBW: begin
          if ((tc == '0) || (LW'(bd_rdata) >= tc)) begin
            j     <= jm1;
            state <= S_RMB;
          end else begin
            ridx  <= bd_rdata;
            state <= S_RMTW;
          end
        end
        S_RMTW: begin
          tc    <= tcm1;
          j     <= jm1;
          state <= S_RMB;
        end

        // join boundary edges to the new point
        S_APE: begin
          if (j == ec) begin
            if (NW'(i + 1'b1) == point_count) begin
              j     <= '0;
              kept  <= '0;
              pend  <= 1'b0;
              state <= S_OTT;
            end else begin
              state <= S_INS;
            end
            i <= i + 1'b1;
          end else begin
            state <= S_APEW;
          end
        end
        S_APEW: begin
          ea    <= ed_rdata[2*IW-1:IW];
          eb    <= ed_rdata[IW-1:0];
          state <= S_APA;
        end
        S_APA: begin
          ax <= rel_x; ay <= rel_y;
          state <= S_APB;
        end
        S_APB: begin
          bx <= rel_x; by <= rel_y;
          mcnt   <= MUL_CROSS;
          mfirst <= 1'b1;
          mret   <= 1'b1;
          state  <= S_MULS;
        end
        S_APDEC: begin
          if (tc < LW'(LIST_DEPTH)) begin
            tc <= tc + 1'b1;
          end
          j     <= j + 1'b1;
          state <= S_APE;
        end

        // result stream; one triangle held back to flag the last word
        S_OTT: begin
          if ((j == tc) || (kept == KW'(MAX_RESULTS))) begin
            state <= S_OTEND;
          end else begin
            state <= S_OTTW;
          end
        end
        S_OTTW: begin
          tv0   <= tr_rdata[3*IW-1:2*IW];
          tv1   <= tr_rdata[2*IW-1:IW];
          tv2   <= tr_rdata[IW-1:0];
          state <= S_OTCHK;
        end
        S_OTCHK: begin
          if (!qual) begin
            j     <= j + 1'b1;
            state <= S_OTT;
          end else if (!pend || ofree) begin
            if (pend) begin
              ovalid <= 1'b1;
              o_a    <= pa[VW-1:0];
              o_b    <= pb[VW-1:0];
              o_c    <= pc[VW-1:0];
              o_has  <= 1'b1;
              o_ovf  <= overflow_seen;
              o_last <= 1'b0;
            end
            pend  <= 1'b1;
            pa    <= tv0;
            pb    <= tv1;
            pc    <= tv2;
            kept  <= kept + 1'b1;
            j     <= j + 1'b1;
            state <= S_OTT;
          end
        end
        S_OTEND: begin
          if (ofree) begin
            ovalid        <= 1'b1;
            o_a           <= pend ? pa[VW-1:0] : '0;
            o_b           <= pend ? pb[VW-1:0] : '0;
            o_c           <= pend ? pc[VW-1:0] : '0;
            o_has         <= pend;
            o_ovf         <= overflow_seen;
            o_last        <= 1'b1;
            pend          <= 1'b0;
            point_count   <= '0;
            bb_minx       <= '0;
            bb_maxx       <= '0;
            bb_miny       <= '0;
            bb_maxy       <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/delaunay_triangulation_tb.sv */
// Testbench for the Delaunay triangulation block: point sets in, checked triangle words out.
module delaunay_triangulation_tb;
  import dt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One output word as the predictor expects it.
  typedef struct {
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] c;
    logic          has;
    logic          ovf;
    logic          last;
  } tri_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dt_point_if pts ();
  dt_tri_if   tris ();

  delaunay_triangulation u_top (
    .clk       (clk),
    .rst       (rst),
    .points    (pts),
    .triangles (tris)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop, well above the slowest legal run.
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor state: doubled coordinates plus three super vertices.
  // ------------------------------------------------------------------
  int        px [0:STORE_DEPTH-1];
  int        py [0:STORE_DEPTH-1];
  int        n_pts;
  int        box_x0, box_y0, box_x1, box_y1;
  bit        ovf_seen;
  int        tri_v [0:LIST_DEPTH-1][0:2];
  int        tri_n;
  int        bad_idx [0:LIST_DEPTH-1];
  int        bad_n;
  int        edg [0:LIST_DEPTH-1][0:1];
  int        edg_n;

  tri_word_t tri_expect_q [$];
  int        err_cnt = 0;

  // Idling, in percent per side; hold_left forces a long receiver stall.
  int        snd_idle = 38;
  int        rcv_idle = 75;
  int        hold_left = 0;

  function automatic longint cross_of(int a, int b, int c);
    longint bx, by, cx, cy;
    bx = longint'(px[b]) - px[a];
    by = longint'(py[b]) - py[a];
    cx = longint'(px[c]) - px[a];
    cy = longint'(py[c]) - py[a];
    return bx * cy - by * cx;
  endfunction

  // Strictly inside the circumcircle, exact on 128 bits.
  function automatic bit in_circle(int p, int a, int b, int c);
    longint ax, ay, bx, by, cx, cy;
    logic signed [127:0] s1, s2, s3, k1, k2, k3, det;
    ax = longint'(px[a]) - px[p];
    ay = longint'(py[a]) - py[p];
    bx = longint'(px[b]) - px[p];
    by = longint'(py[b]) - py[p];
    cx = longint'(px[c]) - px[p];
    cy = longint'(py[c]) - py[p];
    s1 = ax * ax + ay * ay;
    s2 = bx * bx + by * by;
    s3 = cx * cx + cy * cy;
    k1 = bx * cy - by * cx;
    k2 = ax * cy - ay * cx;
    k3 = ax * by - ay * bx;
    det = s1 * k1 - s2 * k2 + s3 * k3;
    if (cross_of(a, b, c) > 0) return det > 0;
    return det < 0;
  endfunction

  // Shared cavity edges cancel; otherwise append.
  function automatic void cavity_edge(int a, int b);
    int k, m;
    for (k = 0; k < edg_n; k++) begin
      if (edg[k][0] == b && edg[k][1] == a) begin
        for (m = k; m < edg_n - 1; m++) begin
          edg[m][0] = edg[m+1][0];
          edg[m][1] = edg[m+1][1];
        end
        edg_n--;
        return;
      end
    end
    if (edg_n < LIST_DEPTH) begin
      edg[edg_n][0] = a;
      edg[edg_n][1] = b;
      edg_n++;
    end
  endfunction

  function automatic void push_word(int a, int b, int c, bit has);
    tri_word_t w;
    w.a = a[VW-1:0];
    w.b = b[VW-1:0];
    w.c = c[VW-1:0];
    w.has = has;
    w.ovf = ovf_seen;
    w.last = 1'b0;
    tri_expect_q = {tri_expect_q, w};
  endfunction

  // Bowyer-Watson over the stored set, queueing the surviving triangles.
  function automatic void triangulate();
    int n, i, j, k, idx, a, b, s, cx, cy, dx, dy, d;
    int tmp [0:2];
    n = n_pts;
    k = 0;
    if (n >= 3) begin
      cx = box_x0 + box_x1;
      cy = box_y0 + box_y1;
      dx = box_x1 - box_x0;
      dy = box_y1 - box_y0;
      d = 2 * (dx > dy ? dx : dy);
      px[n] = cx - 20 * d;   py[n] = cy - d;
      px[n+1] = cx;          py[n+1] = cy + 20 * d;
      px[n+2] = cx + 20 * d; py[n+2] = cy - d;
      tri_v[0][0] = n; tri_v[0][1] = n + 1; tri_v[0][2] = n + 2;
      tri_n = 1;
      for (i = 0; i < n; i++) begin
        bad_n = 0;
        for (j = 0; j < tri_n; j++)
          if (in_circle(i, tri_v[j][0], tri_v[j][1], tri_v[j][2]) && bad_n < LIST_DEPTH) begin
            bad_idx[bad_n] = j;
            bad_n++;
          end
        edg_n = 0;
        for (j = 0; j < bad_n; j++) begin
          idx = bad_idx[j];
          cavity_edge(tri_v[idx][0], tri_v[idx][1]);
          cavity_edge(tri_v[idx][1], tri_v[idx][2]);
          cavity_edge(tri_v[idx][2], tri_v[idx][0]);
        end
        // swap-remove, highest list index first
        for (j = bad_n; j > 0; j--) begin
          idx = bad_idx[j-1];
          if (tri_n == 0 || idx >= tri_n) continue;
          for (s = 0; s < 3; s++) tmp[s] = tri_v[idx][s];
          for (s = 0; s < 3; s++) tri_v[idx][s] = tri_v[tri_n-1][s];
          for (s = 0; s < 3; s++) tri_v[tri_n-1][s] = tmp[s];
          tri_n--;
        end
        for (j = 0; j < edg_n; j++) begin
          a = edg[j][0];
          b = edg[j][1];
          if (cross_of(a, b, i) <= 0) begin
            s = a; a = b; b = s;
          end
          if (tri_n < LIST_DEPTH) begin
            tri_v[tri_n][0] = a; tri_v[tri_n][1] = b; tri_v[tri_n][2] = i;
            tri_n++;
          end
        end
      end
      for (j = 0; j < tri_n; j++) begin
        if (tri_v[j][0] >= n || tri_v[j][1] >= n || tri_v[j][2] >= n) continue;
        if (k < MAX_RESULTS) begin
          push_word(tri_v[j][0], tri_v[j][1], tri_v[j][2], 1'b1);
          k++;
        end
      end
    end
    if (k == 0) push_word(0, 0, 0, 1'b0);
    tri_expect_q[$].last = 1'b1;
    n_pts = 0;
    box_x0 = 0; box_y0 = 0; box_x1 = 0; box_y1 = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void predict_point(logic [FIELD_W-1:0] xr, logic [FIELD_W-1:0] yr,
                                        logic last);
    int x, y;
    x = int'($signed(xr[COORD_BITS-1:0]));
    y = int'($signed(yr[COORD_BITS-1:0]));
    if (n_pts < MAX_POINTS) begin
      if (n_pts == 0) begin
        box_x0 = x; box_x1 = x; box_y0 = y; box_y1 = y;
      end else begin
        if (x < box_x0) box_x0 = x;
        if (x > box_x1) box_x1 = x;
        if (y < box_y0) box_y0 = y;
        if (y > box_y1) box_y1 = y;
      end
      px[n_pts] = 2 * x;
      py[n_pts] = 2 * y;
      n_pts++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) triangulate();
  endfunction

  // ------------------------------------------------------------------
  // Sender: one point word, with a random gap in front of it.
  // valid is only lowered when a gap follows, never lowered and raised
  // in the same step.
  // ------------------------------------------------------------------
  task automatic send_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle && gap < 12) gap++;
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts.valid      <= 1'b1;
    pts.point_x    <= x;
    pts.point_y    <= y;
    pts.last_point <= last;
    do @(posedge clk); while (!pts.ready);
    predict_point(x, y, last);
  endtask

  task automatic drop_valid();
    pts.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: checks each accepted word, then picks ready for the next edge.
  initial begin
    tri_word_t w;
    tris.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (tris.valid && tris.ready) begin
        if (tri_expect_q.size() == 0) begin
          $display("%0t: unexpected word a=%0d b=%0d c=%0d has=%0b ovf=%0b last=%0b",
                   $time, tris.vertex_a, tris.vertex_b, tris.vertex_c,
                   tris.has_triangle, tris.overflow, tris.last_triangle);
          err_cnt++;
        end else begin
          w = tri_expect_q.pop_front();
          if (tris.vertex_a !== w.a || tris.vertex_b !== w.b || tris.vertex_c !== w.c ||
              tris.has_triangle !== w.has || tris.overflow !== w.ovf ||
              tris.last_triangle !== w.last) begin
            $display("%0t: mismatch exp a=%0d b=%0d c=%0d has=%0b ovf=%0b last=%0b",
                     $time, w.a, w.b, w.c, w.has, w.ovf, w.last);
            $display("%0t:          act a=%0d b=%0d c=%0d has=%0b ovf=%0b last=%0b",
                     $time, tris.vertex_a, tris.vertex_b, tris.vertex_c,
                     tris.has_triangle, tris.overflow, tris.last_triangle);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        tris.ready <= 1'b0;
      end else begin
        tris.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // ------------------------------------------------------------------
  // Test tasks
  // ------------------------------------------------------------------
  int item_cnt = 0;

  task automatic send_set(int n, int mode);
    int i, c0, c1;
    logic [FIELD_W-1:0] x, y;
    c0 = $urandom_range(2000) - 1000;
    c1 = $urandom_range(2000) - 1000;
    for (i = 0; i < n; i++) begin
      case (mode)
        0: begin   // anywhere in the full range
          x = FIELD_W'($urandom());
          y = FIELD_W'($urandom());
        end
        1: begin   // tight cluster
          x = FIELD_W'(c0 + $urandom_range(40) - 20);
          y = FIELD_W'(c1 + $urandom_range(40) - 20);
        end
        2: begin   // coarse grid: collinear and cocircular sets
          x = FIELD_W'(c0 + 100 * $urandom_range(4));
          y = FIELD_W'(c1 + 100 * $urandom_range(4));
        end
        default: begin  // extremes mixed with random
          x = $urandom_range(1) ? 16'h8000 : 16'h7fff;
          y = $urandom_range(2) == 0 ? 16'h0000 : 16'($urandom());
        end
      endcase
      send_point(x, y, i == n - 1);
      item_cnt++;
    end
  endtask

  task automatic test_short_sets();
    send_point(16'd5, 16'd5, 1'b1);                 // single point
    send_point(16'd0, 16'd0, 1'b0);                 // two points
    send_point(16'd9, 16'hfff7, 1'b1);
  endtask

  task automatic test_extreme_corners();
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h8000, 1'b0);
    send_point(16'h0000, 16'h7fff, 1'b1);
    send_point(16'h7fff, 16'h7fff, 1'b0);
    send_point(16'h8000, 16'h7fff, 1'b0);
    send_point(16'hffff, 16'h8000, 1'b1);
  endtask

  task automatic test_degenerate_sets();
    send_point(16'd1, 16'd1, 1'b0);                 // collinear
    send_point(16'd2, 16'd2, 1'b0);
    send_point(16'd3, 16'd3, 1'b1);
    send_point(16'd10, 16'd10, 1'b0);               // duplicate point
    send_point(16'd10, 16'd10, 1'b0);
    send_point(16'd20, 16'd0, 1'b0);
    send_point(16'd0, 16'd30, 1'b1);
    send_point(16'hff9c, 16'hff9c, 1'b0);           // square, all cocircular
    send_point(16'd100, 16'hff9c, 1'b0);
    send_point(16'd100, 16'd100, 1'b0);
    send_point(16'hff9c, 16'd100, 1'b1);
  endtask

  task automatic test_overflow();
    send_set(MAX_POINTS + 3, 0);
  endtask

  task automatic test_random_sets(int goal);
    int n, r;
    while (item_cnt < goal) begin
      r = $urandom_range(19);
      n = (r == 0) ? $urandom_range(1, 2) : (r < 3 ? $urandom_range(10, 16) : $urandom_range(3, 8));
      send_set(n, $urandom_range(3));
    end
  endtask

  // Receiver holds off while the next set keeps coming, so input backs up.
  task automatic test_output_stall();
    send_set(6, 1);
    hold_left = 40000;
    send_set(5, 0);
    send_set(4, 2);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (tri_expect_q.size() != 0) begin
      @(posedge clk);
      guard++;
      if (guard > 2_000_000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  endtask

  initial begin
    pts.valid      <= 1'b0;
    pts.point_x    <= '0;
    pts.point_y    <= '0;
    pts.last_point <= 1'b0;
    n_pts = 0;
    box_x0 = 0; box_y0 = 0; box_x1 = 0; box_y1 = 0;
    ovf_seen = 1'b0;
    tri_n = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_sets();
    test_extreme_corners();
    test_degenerate_sets();
    test_random_sets(90);

    snd_idle = 75;
    rcv_idle = 38;
    test_overflow();
    test_random_sets(180);

    snd_idle = 0;
    rcv_idle = 0;
    test_output_stall();
    test_random_sets(245);
    drop_valid();

    wait_drained();
    repeat (500) @(posedge clk);
    if (err_cnt == 0 && tri_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dt_pkg.sv
src/dt_if.sv
src/dt_ram.sv
src/dt_mac.sv
src/delaunay_triangulation.sv
tb/sv/delaunay_triangulation_tb.sv
